// File: design/tmx_pkg.sv
// ----------------------------------------------------------------------------
// tmx_pkg
// Shared types and constants for the trie maximum-xor pair block.
// ----------------------------------------------------------------------------
`default_nettype none

package tmx_pkg;

  // width of the value and result fields on the channels
  localparam int unsigned ValueW = 64;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_EV,
    S_INS_AL,
    S_QRY_RD,
    S_QRY_EV,
    S_DONE
  } tmx_state_e;

endpackage

`default_nettype wire

// File: design/tmx_if.sv
// ----------------------------------------------------------------------------
// tmx_in_if / tmx_out_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface tmx_in_if;
  import tmx_pkg::*;

  logic              valid;
  logic              ready;
  logic [ValueW-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface tmx_out_if;
  import tmx_pkg::*;

  logic              valid;
  logic              ready;
  logic [ValueW-1:0] best_xor;
  logic [ValueW-1:0] item_xor;
  logic              store_full;

  modport source (output valid, output best_xor, output item_xor, output store_full,
                  input ready);
  modport sink   (input valid, input best_xor, input item_xor, input store_full,
                  output ready);
endinterface

`default_nettype wire

// File: design/trie_max_xor_pair.sv
// ----------------------------------------------------------------------------
// trie_max_xor_pair
// Inserts each word into a binary trie while the store has room, then walks
// the trie for the largest xor against any stored value and keeps a running maximum.
// ----------------------------------------------------------------------------
//   channel  | dir | handshake     | payload
//   in_i     | in  | valid / ready | value
//   out_o    | out | valid / ready | best_xor, item_xor, store_full
//
// one word at a time: the next word is taken only after the last result is loaded
// into the output register; when the store is full only the query runs. each trie
// level costs one dependent node read of registered data, for the insert walk and
// again for the query walk, until the insert grows a new branch of fresh nodes.
// reset takes effect at once; no memory clearing pass, the root reads empty.
// a finished result waits in the output register while the next word is taken;
// the walk stalls only in its final state, S_DONE, if that register is still full.
// ----------------------------------------------------------------------------
`default_nettype none

module trie_max_xor_pair #(
  parameter int unsigned NODE_CAPACITY = 4096,
  parameter int unsigned DATA_BITS     = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tmx_in_if.sink    in_i,
  tmx_out_if.source out_o
);
  import tmx_pkg::*;

  localparam int unsigned IdxW = $clog2(NODE_CAPACITY);
  localparam int unsigned CntW = $clog2(NODE_CAPACITY + 1);
  localparam int unsigned LvlW = $clog2(DATA_BITS);
  localparam logic [CntW-1:0] FullAt = CntW'(NODE_CAPACITY - DATA_BITS + 1);
  localparam logic [LvlW-1:0] TopLvl = LvlW'(DATA_BITS - 1);

  tmx_state_e          state_q, state_d;
  logic [LvlW-1:0]     level_q, level_d;
  logic [IdxW-1:0]     node_q, node_d;
  logic [CntW-1:0]     used_q, used_d;
  logic [DATA_BITS-1:0] val_q, val_d;
  logic [DATA_BITS-1:0] xor_q, xor_d;
  logic                full_q, full_d;
  logic [ValueW-1:0]   best_q, best_d;
  logic                ovld_q, ovld_d;
  logic [ValueW-1:0]   oitem_q, oitem_d;
  logic                ofull_q, ofull_d;

  logic                rd_en;
  logic [IdxW-1:0]     rd_addr;
  logic                wr_en;
  logic [IdxW-1:0]     wr_addr;
  logic [2*IdxW-1:0]   wr_data;
  logic [2*IdxW-1:0]   rd_data;

  logic [IdxW-1:0]     kid0, kid1;
  logic [LvlW-1:0]     lvl_m1;
  logic                cur_bit, nxt_bit;
  logic [IdxW-1:0]     new_idx;
  logic [IdxW-1:0]     ins_child, opp_child, same_child, qry_next;
  logic [ValueW-1:0]   item_ext;

  tmx_node_store #(
    .NODE_CAPACITY(NODE_CAPACITY)
  ) u_node_store (
    .clk_i,
    .rst_ni,
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_data_o(rd_data)
  );

  assign kid0       = rd_data[IdxW-1:0];
  assign kid1       = rd_data[2*IdxW-1:IdxW];
  assign lvl_m1     = level_q - 1'b1;
  assign cur_bit    = val_q[level_q];
  assign nxt_bit    = val_q[lvl_m1];
  assign new_idx    = used_q[IdxW-1:0];
  assign ins_child  = cur_bit ? kid1 : kid0;
  assign same_child = ins_child;
  assign opp_child  = cur_bit ? kid0 : kid1;
  assign qry_next   = (opp_child != '0) ? opp_child : same_child;
  assign item_ext   = ValueW'(xor_q);

  always_comb begin
    state_d = state_q;
    level_d = level_q;
    node_d  = node_q;
    used_d  = used_q;
    val_d   = val_q;
    xor_d   = xor_q;
    full_d  = full_q;
    best_d  = best_q;
    oitem_d = oitem_q;
    ofull_d = ofull_q;
    ovld_d  = ovld_q && !out_o.ready;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = node_q;
    wr_data = '0;
    in_i.ready = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          val_d   = in_i.value[DATA_BITS-1:0];
          level_d = TopLvl;
          if (used_q >= FullAt) begin
            full_d  = 1'b1;
            state_d = S_QRY_RD;
          end else begin
            full_d  = 1'b0;
            state_d = S_INS_RD;
          end
        end
      end
      S_INS_RD: begin
        rd_en   = 1'b1;
        node_d  = '0;
        state_d = S_INS_EV;
      end
      S_INS_EV: begin
        if (ins_child != '0) begin
          if (level_q == '0) begin
            state_d = S_QRY_RD;
          end else begin
            rd_en   = 1'b1;
            rd_addr = ins_child;
            node_d  = ins_child;
            level_d = lvl_m1;
          end
        end else begin
          // missing child: hook a fresh node under the current one
          wr_en   = 1'b1;
          wr_data = cur_bit ? {new_idx, kid0} : {kid1, new_idx};
          node_d  = new_idx;
          used_d  = used_q + 1'b1;
          state_d = S_INS_AL;
        end
      end
      S_INS_AL: begin
        // fresh chain, one new node per level down to the leaf
        wr_en = 1'b1;
        if (level_q == '0) begin
          wr_data = '0;
          state_d = S_QRY_RD;
        end else begin
          wr_data = nxt_bit ? {new_idx, IdxW'(0)} : {IdxW'(0), new_idx};
          node_d  = new_idx;
          used_d  = used_q + 1'b1;
          level_d = lvl_m1;
        end
      end
      S_QRY_RD: begin
        rd_en   = 1'b1;
        level_d = TopLvl;
        xor_d   = '0;
        state_d = S_QRY_EV;
      end
      S_QRY_EV: begin
        if (opp_child != '0) begin
          xor_d = xor_q | (DATA_BITS'(1) << level_q);
        end
        if ((qry_next == '0) || (level_q == '0)) begin
          state_d = S_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = qry_next;
          level_d = lvl_m1;
        end
      end
      S_DONE: begin
        if (!ovld_q || out_o.ready) begin
          ovld_d  = 1'b1;
          oitem_d = item_ext;
          ofull_d = full_q;
          best_d  = (item_ext > best_q) ? item_ext : best_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= CntW'(1);
      best_q  <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      best_q  <= best_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    level_q <= level_d;
    node_q  <= node_d;
    val_q   <= val_d;
    xor_q   <= xor_d;
    full_q  <= full_d;
    oitem_q <= oitem_d;
    ofull_q <= ofull_d;
  end

  assign out_o.valid      = ovld_q;
  assign out_o.best_xor   = best_q;
  assign out_o.item_xor   = oitem_q;
  assign out_o.store_full = ofull_q;

endmodule

`default_nettype wire

// File: design/tmx_node_store.sv
// ----------------------------------------------------------------------------
// tmx_node_store
// Trie node memory: one entry per node holding both child indices, one read
// and one write port, registered read data. The root reads as empty until
// it is first written.
// ----------------------------------------------------------------------------
`default_nettype none

module tmx_node_store #(
  parameter int unsigned NODE_CAPACITY = 4096,
  localparam int unsigned IdxW = $clog2(NODE_CAPACITY)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [IdxW-1:0]   rd_addr_i,
  input  logic              wr_en_i,
  input  logic [IdxW-1:0]   wr_addr_i,
  input  logic [2*IdxW-1:0] wr_data_i,
  output logic [2*IdxW-1:0] rd_data_o
);

  logic [2*IdxW-1:0] mem_q [NODE_CAPACITY];
  logic [2*IdxW-1:0] rdata_q;
  logic              root_init_q;
  logic              rd_zero_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  // root has no children after reset, without touching the array
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_init_q <= 1'b0;
      rd_zero_q   <= 1'b0;
    end else begin
      if (wr_en_i && (wr_addr_i == '0)) begin
        root_init_q <= 1'b1;
      end
      if (rd_en_i) begin
        rd_zero_q <= (rd_addr_i == '0) && !root_init_q;
      end
    end
  end

  assign rd_data_o = rd_zero_q ? '0 : rdata_q;

endmodule

`default_nettype wire

// File: design/tmx_checker.sv
// ----------------------------------------------------------------------------
// tmx_sva
// Port-level checks for trie_max_xor_pair, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tmx_sva #(
  parameter int unsigned DATA_BITS = 64
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [63:0] best_xor_i,
  input wire logic [63:0] item_xor_i,
  input wire logic        store_full_i
);

  // one word in flight: no second word right after an accepted one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("word accepted back to back");

  // running maximum never below the word's own result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (best_xor_i >= item_xor_i))
    else $error("best_xor below item_xor");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((item_xor_i >> DATA_BITS) == 64'd0))
    else $error("item_xor wider than data bits");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result word dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      ($stable(best_xor_i) && $stable(item_xor_i) && $stable(store_full_i)))
    else $error("result word changed while stalled");

endmodule

bind trie_max_xor_pair tmx_sva #(
  .DATA_BITS(DATA_BITS)
) u_tmx_sva (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .best_xor_i  (out_o.best_xor),
  .item_xor_i  (out_o.item_xor),
  .store_full_i(out_o.store_full)
);

`default_nettype wire
